>>> rtl/core/hcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared types, constants and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcd_pkg;

    // widths of the counters and the capacity register
    localparam int CAP_WIDTH   = 25;
    localparam int COUNT_WIDTH = 24;
    localparam int SIZE_WIDTH  = 31;
    localparam int CHARS_WIDTH = 4;
    localparam int SKIP_WIDTH  = 2;

    // size line ends after this many characters when no cr shows up
    localparam logic [CHARS_WIDTH-1:0] SIZE_LINE_MAX = 4'd15;

    // bytes skipped after a long size line and after each chunk
    localparam logic [SKIP_WIDTH-1:0] SKIP_TWO = 2'd2;
    // a cr is the first of the two bytes after the size line
    localparam logic [SKIP_WIDTH-1:0] SKIP_ONE = 2'd1;

    localparam logic [7:0] CHAR_CR = 8'h0D;

    // capacity after reset and the payload limit that follows from it
    localparam logic [CAP_WIDTH-1:0]   CAP_RESET   = 25'd8192;
    localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = 24'd8191;

    // one raw body byte
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    // one decoded result
    typedef struct packed {
        logic                   byte_valid;
        logic [7:0]             out_byte;
        logic                   end_of_body;
        logic [COUNT_WIDTH-1:0] total_length;
    } out_item_t;

    // hex digit decode: bit 4 flags a hex character, bits 3:0 its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                v = c - 8'h30;
                return {1'b1, v[3:0]};
            end
            if (c >= 8'h61 && c <= 8'h66) begin
                v = c - 8'h57;
                return {1'b1, v[3:0]};
            end
            if (c >= 8'h41 && c <= 8'h46) begin
                v = c - 8'h37;
                return {1'b1, v[3:0]};
            end
            return 5'b0_0000;
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Chunked transfer body decoder: strips size lines and chunk framing and
// passes payload bytes on, with an end flag and the body's byte total.
// ----------------------------------------------------------------------------
// One body byte is taken per cycle while the skid stage is empty. A byte
// accepted into the input register is decoded there by the framing state
// machine, which updates as the byte is consumed, and any result it causes
// is loaded into the result register, or into the skid stage when the
// result register still holds an untaken result. The skid stage behind
// the result register takes one further result, so the input side keeps
// moving while m_ready is low until it fills. The payload limit is derived
// from cfg_wr_data when cfg_wr_en writes it (capacity minus one, capped at
// the 24-bit counter), so a new value applies to bytes accepted afterwards.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [hcd_pkg::CAP_WIDTH-1:0] cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire hcd_pkg::in_item_t             s_item,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output hcd_pkg::out_item_t                 m_item
);
    import hcd_pkg::*;

    logic [COUNT_WIDTH-1:0] limit_reg;
    logic [CAP_WIDTH-1:0]   cap_dec;
    logic                   res_valid;
    logic                   res_ready;
    out_item_t              res_item;

    // payload limit: capacity minus one, zero capacity acts like one
    assign cap_dec = (cfg_wr_data != '0) ? cfg_wr_data - 1'b1 : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cap_dec[CAP_WIDTH-1] ? '1 : cap_dec[COUNT_WIDTH-1:0];
        end
    end

    hcd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .limit     (limit_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    hcd_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_ready (res_ready),
        .in_item  (res_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    // a result without a payload byte is always an end of body
    a_empty_result_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.byte_valid |-> m_item.end_of_body)
        else $error("result with neither payload nor end flag");

    // total only reported on the end result
    a_total_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.end_of_body |-> m_item.total_length == '0)
        else $error("non-zero total on a result without end flag");

    // payload byte zero when not valid
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.byte_valid |-> m_item.out_byte == 8'h00)
        else $error("out_byte set without byte_valid");

    // no result can emerge in the first cycle after reset
    a_quiet_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule
`default_nettype wire

>>> rtl/core/hcd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcd_parser
// Input register and chunk framing state machine. Each registered byte is
// consumed once the result side has room and produces at most one result.
// ----------------------------------------------------------------------------
module hcd_parser (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire hcd_pkg::in_item_t               s_item,
    input  wire logic [hcd_pkg::COUNT_WIDTH-1:0] limit,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output hcd_pkg::out_item_t                   res_item
);
    import hcd_pkg::*;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_HSKIP,
        PH_DATA,
        PH_TSKIP,
        PH_DONE
    } phase_t;

    // input register
    logic     in_valid_reg;
    in_item_t in_item_reg;

    // framing state
    phase_t                 phase_reg,       phase_next;
    logic [SIZE_WIDTH-1:0]  size_accum_reg,  size_accum_next;
    logic [CHARS_WIDTH-1:0] size_chars_reg,  size_chars_next;
    logic                   hex_stopped_reg, hex_stopped_next;
    logic [SKIP_WIDTH-1:0]  skip_left_reg,   skip_left_next;
    logic [SIZE_WIDTH-1:0]  chunk_left_reg,  chunk_left_next;
    logic [COUNT_WIDTH-1:0] out_total_reg,   out_total_next;

    logic                   fire;
    logic [4:0]             hex;
    logic [SKIP_WIDTH-1:0]  skip_dec;
    logic [SIZE_WIDTH-1:0]  chunk_dec;
    logic                   pay_valid;
    logic                   body_end;

    // a registered byte is consumed once the result side has room
    assign fire    = in_valid_reg && res_ready;
    assign s_ready = !in_valid_reg || fire;

    assign hex       = hex_digit(in_item_reg.in_byte);
    assign skip_dec  = (skip_left_reg != '0) ? skip_left_reg - SKIP_ONE : '0;
    assign chunk_dec = (chunk_left_reg != '0) ? chunk_left_reg - 1'b1 : '0;

    // next state and result for the registered byte
    always_comb begin
        phase_next       = phase_reg;
        size_accum_next  = size_accum_reg;
        size_chars_next  = size_chars_reg;
        hex_stopped_next = hex_stopped_reg;
        skip_left_next   = skip_left_reg;
        chunk_left_next  = chunk_left_reg;
        out_total_next   = out_total_reg;
        pay_valid        = 1'b0;
        body_end         = 1'b0;
        res_valid        = 1'b0;
        res_item         = '0;

        if (phase_reg == PH_DONE) begin
            // ignore bytes until the last one re-arms
            if (in_item_reg.in_last) begin
                phase_next       = PH_SIZE;
                size_accum_next  = '0;
                size_chars_next  = '0;
                hex_stopped_next = 1'b0;
                skip_left_next   = '0;
                chunk_left_next  = '0;
                out_total_next   = '0;
            end
        end else begin
            if (out_total_reg >= limit) begin
                body_end = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_SIZE: begin
                        if (in_item_reg.in_byte == CHAR_CR) begin
                            phase_next     = PH_HSKIP;
                            skip_left_next = SKIP_ONE;
                        end else begin
                            if (!hex[4]) begin
                                hex_stopped_next = 1'b1;
                            end else if (!hex_stopped_reg) begin
                                // saturate once a further digit would overflow
                                if (size_accum_reg[SIZE_WIDTH-1 -: 4] != 4'h0) begin
                                    size_accum_next = '1;
                                end else begin
                                    size_accum_next = {size_accum_reg[SIZE_WIDTH-5:0],
                                                       hex[3:0]};
                                end
                            end
                            size_chars_next = size_chars_reg + 1'b1;
                            if (size_chars_next >= SIZE_LINE_MAX) begin
                                phase_next     = PH_HSKIP;
                                skip_left_next = SKIP_TWO;
                            end
                        end
                    end
                    PH_HSKIP: begin
                        skip_left_next = skip_dec;
                        if (skip_dec == '0) begin
                            if (size_accum_reg == '0) begin
                                body_end = 1'b1;
                            end else begin
                                phase_next      = PH_DATA;
                                chunk_left_next = size_accum_reg;
                            end
                        end
                    end
                    PH_DATA: begin
                        pay_valid       = 1'b1;
                        out_total_next  = out_total_reg + 1'b1;
                        chunk_left_next = chunk_dec;
                        if (out_total_next >= limit) begin
                            body_end = 1'b1;
                        end else if (chunk_dec == '0) begin
                            phase_next     = PH_TSKIP;
                            skip_left_next = SKIP_TWO;
                        end
                    end
                    default: begin
                        skip_left_next = skip_dec;
                        if (skip_dec == '0) begin
                            phase_next       = PH_SIZE;
                            size_accum_next  = '0;
                            size_chars_next  = '0;
                            hex_stopped_next = 1'b0;
                        end
                    end
                endcase
            end

            if (in_item_reg.in_last) begin
                body_end = 1'b1;
            end

            // result fields
            res_valid             = in_valid_reg && (pay_valid || body_end);
            res_item.byte_valid   = pay_valid;
            res_item.out_byte     = pay_valid ? in_item_reg.in_byte : 8'h00;
            res_item.end_of_body  = body_end;
            res_item.total_length = body_end ? out_total_next : '0;

            // end of body: re-arm on the last byte, otherwise wait for it
            if (body_end) begin
                if (in_item_reg.in_last) begin
                    phase_next       = PH_SIZE;
                    size_accum_next  = '0;
                    size_chars_next  = '0;
                    hex_stopped_next = 1'b0;
                    skip_left_next   = '0;
                    chunk_left_next  = '0;
                    out_total_next   = '0;
                end else begin
                    phase_next = PH_DONE;
                end
            end
        end
    end

    // input register and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            phase_reg       <= PH_SIZE;
            size_accum_reg  <= '0;
            size_chars_reg  <= '0;
            hex_stopped_reg <= 1'b0;
            skip_left_reg   <= '0;
            chunk_left_reg  <= '0;
            out_total_reg   <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
                in_item_reg  <= s_item;
            end
            if (fire) begin
                phase_reg       <= phase_next;
                size_accum_reg  <= size_accum_next;
                size_chars_reg  <= size_chars_next;
                hex_stopped_reg <= hex_stopped_next;
                skip_left_reg   <= skip_left_next;
                chunk_left_reg  <= chunk_left_next;
                out_total_reg   <= out_total_next;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/hcd_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcd_out_buf
// Result register with a skid stage, so the parser can hand over one more
// result while a result waits to be taken.
// ----------------------------------------------------------------------------
module hcd_out_buf (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hcd_pkg::out_item_t in_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output hcd_pkg::out_item_t      m_item
);
    import hcd_pkg::*;

    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      skid_valid_reg;
    out_item_t skid_item_reg;
    logic      push;
    logic      pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = out_valid_reg && m_ready;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_item_reg;

    // result register refills from the skid stage first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || pop) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    out_item_reg   <= skid_item_reg;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= push;
                    out_item_reg  <= in_item;
                end
            end else if (push) begin
                skid_valid_reg <= 1'b1;
                skid_item_reg  <= in_item;
            end
        end
    end

endmodule
`default_nettype wire

>>> tb/tb_http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder
// Self-checking bench for the chunked body decoder. A clocked driver feeds
// raw body bytes from a queue and a clocked monitor takes decoded results.
// Each accepted byte is run through a frame tracker kept in the bench, and
// every result is compared field by field with the oldest prediction.
// Directed framing cases come first, then random bodies, broken framing and
// noise under changing capacities, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder;
    import hcd_pkg::*;

    localparam logic [7:0]         CH_LF        = 8'h0A;
    localparam int unsigned        SIZE_SAT     = 32'h7FFF_FFFF;
    localparam logic [CAP_WIDTH:0] COUNT_MAX    = (CAP_WIDTH+1)'((1 << COUNT_WIDTH) - 1);
    localparam logic [CAP_WIDTH-1:0] CAP_TOP    = 25'd16777216;
    localparam logic [CAP_WIDTH-1:0] CAP_ALL    = 25'h1FF_FFFF;
    localparam int                 QUIET_CYCLES = 10;
    localparam int                 RANDOM_BYTES = 1200;

    typedef enum logic [2:0] {
        ST_SIZE_LINE,
        ST_LINE_SKIP,
        ST_PAYLOAD,
        ST_TRAIL_SKIP,
        ST_DONE
    } frame_state_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CAP_WIDTH-1:0] cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    in_item_t             s_item      = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    out_item_t            m_item;

    // raw bytes waiting to be sent and decoded results still owed
    in_item_t  body_bytes[$];
    out_item_t decoded_due[$];
    out_item_t want;
    int        decode_errors = 0;
    int        active_bytes  = 0;

    // frame tracker state
    logic [CAP_WIDTH-1:0]   capacity;
    frame_state_t           frame;
    int unsigned            size_acc;
    logic [CHARS_WIDTH-1:0] line_chars;
    logic                   hex_halted;
    logic [SKIP_WIDTH-1:0]  skip_cnt;
    int unsigned            chunk_cnt;
    logic [COUNT_WIDTH-1:0] body_total;

    // pacing of both sides
    int send_wait = 0;
    bit send_calm = 1'b0;
    int recv_wait = 0;
    bit recv_calm = 1'b0;

    http_chunked_body_decoder DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // hex character value, -1 for anything else
    function automatic int hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    task automatic restart_body();
        frame      = ST_SIZE_LINE;
        size_acc   = 0;
        line_chars = '0;
        hex_halted = 1'b0;
        skip_cnt   = '0;
        chunk_cnt  = 0;
        body_total = '0;
    endtask

    // advance the frame tracker by one byte and queue any result it owes
    task automatic decode_byte(input in_item_t it);
        out_item_t          res;
        logic [CAP_WIDTH:0] limit;
        int                 d;
        int unsigned        du;
        bit                 pay;
        bit                 fin;
        pay = 1'b0;
        fin = 1'b0;
        // after an end only a last byte matters, and it gives no result
        if (frame == ST_DONE) begin
            if (it.in_last) restart_body();
            return;
        end
        active_bytes++;
        limit = (capacity == '0) ? '0 : {1'b0, capacity} - 1'b1;
        if (limit > COUNT_MAX) limit = COUNT_MAX;
        if (body_total >= limit) begin
            fin = 1'b1;
        end else begin
            case (frame)
                ST_SIZE_LINE: begin
                    if (it.in_byte == CHAR_CR) begin
                        frame    = ST_LINE_SKIP;
                        skip_cnt = SKIP_ONE;
                    end else begin
                        d = hex_val(it.in_byte);
                        if (d < 0) begin
                            hex_halted = 1'b1;
                        end else if (!hex_halted) begin
                            du = d;
                            if (size_acc > ((SIZE_SAT - du) >> 4)) size_acc = SIZE_SAT;
                            else size_acc = (size_acc << 4) + du;
                        end
                        line_chars = line_chars + 1'b1;
                        if (line_chars >= SIZE_LINE_MAX) begin
                            frame    = ST_LINE_SKIP;
                            skip_cnt = SKIP_TWO;
                        end
                    end
                end
                ST_LINE_SKIP: begin
                    if (skip_cnt != 0) skip_cnt--;
                    if (skip_cnt == 0) begin
                        if (size_acc == 0) begin
                            fin = 1'b1;
                        end else begin
                            frame     = ST_PAYLOAD;
                            chunk_cnt = size_acc;
                        end
                    end
                end
                ST_PAYLOAD: begin
                    pay        = 1'b1;
                    body_total = body_total + 1'b1;
                    if (chunk_cnt != 0) chunk_cnt--;
                    if (body_total >= limit) begin
                        fin = 1'b1;
                    end else if (chunk_cnt == 0) begin
                        frame    = ST_TRAIL_SKIP;
                        skip_cnt = SKIP_TWO;
                    end
                end
                default: begin
                    if (skip_cnt != 0) skip_cnt--;
                    if (skip_cnt == 0) begin
                        frame      = ST_SIZE_LINE;
                        size_acc   = 0;
                        line_chars = '0;
                        hex_halted = 1'b0;
                    end
                end
            endcase
        end
        if (it.in_last) fin = 1'b1;
        if (pay || fin) begin
            res.byte_valid   = pay;
            res.out_byte     = pay ? it.in_byte : 8'h00;
            res.end_of_body  = fin;
            res.total_length = fin ? body_total : '0;
            decoded_due.push_back(res);
            if (fin) begin
                if (it.in_last) restart_body();
                else frame = ST_DONE;
            end
        end
    endtask

    // driver: one request per queued byte, random gap after each
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_valid && s_ready) decode_byte(s_item);
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (body_bytes.size() != 0) begin
                    s_item  <= body_bytes.pop_front();
                    s_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
                    send_wait = send_calm ? 0 : $urandom_range(0, 9);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (decoded_due.size() == 0) begin
                    decode_errors++;
                    if (decode_errors <= 10)
                        $display("unexpected result: valid=%0b byte=%02h end=%0b total=%0d",
                                 m_item.byte_valid, m_item.out_byte,
                                 m_item.end_of_body, m_item.total_length);
                end else begin
                    want = decoded_due.pop_front();
                    if (m_item.byte_valid !== want.byte_valid ||
                        m_item.out_byte !== want.out_byte ||
                        m_item.end_of_body !== want.end_of_body ||
                        m_item.total_length !== want.total_length) begin
                        decode_errors++;
                        if (decode_errors <= 10) begin
                            $write("result mismatch: expected valid=%0b byte=%02h end=%0b ",
                                   want.byte_valid, want.out_byte, want.end_of_body);
                            $display("total=%0d, got valid=%0b byte=%02h end=%0b total=%0d",
                                     want.total_length, m_item.byte_valid, m_item.out_byte,
                                     m_item.end_of_body, m_item.total_length);
                        end
                    end
                end
                if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
                recv_wait = recv_calm ? 0 : $urandom_range(0, 9);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input bit last);
        in_item_t it;
        it.in_byte = b;
        it.in_last = last;
        body_bytes.push_back(it);
    endtask

    // size line in hex, mixed case, sometimes padded or with an extension
    task automatic push_size_line(input int unsigned size, input bit last_on_lf);
        int         ndig;
        int         pad;
        logic [3:0] nib;
        ndig = 1;
        while (ndig < 8 && (size >> (4 * ndig)) != 0) ndig++;
        // now and then run the line out to the full length with leading zeros
        pad = ($urandom_range(0, 14) == 0) ? SIZE_LINE_MAX - ndig : $urandom_range(0, 2);
        repeat (pad) push_byte("0", 1'b0);
        for (int k = ndig - 1; k >= 0; k--) begin
            nib = 4'(size >> (4 * k));
            if (nib < 10) push_byte("0" + nib, 1'b0);
            else if ($urandom_range(0, 1)) push_byte("a" + nib - 8'd10, 1'b0);
            else push_byte("A" + nib - 8'd10, 1'b0);
        end
        if (pad + ndig < SIZE_LINE_MAX - 4 && $urandom_range(0, 4) == 0) begin
            push_byte(";", 1'b0);
            push_byte("x", 1'b0);
            push_byte("=", 1'b0);
            push_byte("1", 1'b0);
        end
        push_byte(CHAR_CR, 1'b0);
        push_byte(CH_LF, last_on_lf);
    endtask

    // well-formed body with random chunks and content
    task automatic push_body();
        int size;
        repeat ($urandom_range(0, 4)) begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
            push_size_line(size, 1'b0);
            repeat (size) push_byte(8'($urandom_range(0, 255)), 1'b0);
            if ($urandom_range(0, 9) == 0) begin
                push_byte(8'($urandom_range(0, 255)), 1'b0);
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                push_byte(CHAR_CR, 1'b0);
                push_byte(CH_LF, 1'b0);
            end
        end
        // closing zero chunk, sometimes cut short at its line feed
        if ($urandom_range(0, 3) == 0) begin
            push_size_line(0, 1'b1);
        end else begin
            push_size_line(0, 1'b0);
            push_byte(CHAR_CR, 1'b0);
            push_byte(CH_LF, 1'b1);
        end
    endtask

    // broken framing and noise
    task automatic push_broken();
        int size;
        case ($urandom_range(0, 4))
            0: begin
                // body cut off in the middle of a chunk
                size = $urandom_range(2, 16);
                push_size_line(size, 1'b0);
                repeat ($urandom_range(0, size - 1)) push_byte(8'($urandom_range(0, 255)), 1'b0);
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            1: begin
                // prefix or sign in front of the digits stops the scan
                case ($urandom_range(0, 3))
                    0: push_byte(" ", 1'b0);
                    1: push_byte("-", 1'b0);
                    2: push_byte("+", 1'b0);
                    default: begin
                        push_byte("0", 1'b0);
                        push_byte("x", 1'b0);
                    end
                endcase
                push_byte("1", 1'b0);
                push_byte("A", 1'b0);
                push_byte(CHAR_CR, 1'b0);
                push_byte(CH_LF, 1'b0);
                repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0);
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            2: begin
                // size past the saturation point
                repeat ($urandom_range(8, 12)) push_byte($urandom_range(0, 1) ? "F" : "f", 1'b0);
                push_byte(CHAR_CR, 1'b0);
                push_byte(CH_LF, 1'b0);
                repeat ($urandom_range(0, 20)) push_byte(8'($urandom_range(0, 255)), 1'b0);
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            3: begin
                repeat ($urandom_range(0, 11))
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin
                // noise with no last byte, leaves the body open
                repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        endcase
    endtask

    function automatic logic [CAP_WIDTH-1:0] pick_capacity();
        case ($urandom_range(0, 9))
            0: return 25'd1;
            1: return 25'd2;
            2: return 25'($urandom_range(3, 40));
            3: return 25'($urandom_range(41, 400));
            4: return CAP_TOP;
            5: return CAP_ALL;
            6: return '0;
            default: return CAP_RESET;
        endcase
    endfunction

    // hold off until every request is taken and every result is back
    task automatic wait_quiet();
        do @(posedge aclk);
        while (body_bytes.size() != 0 || s_valid || decoded_due.size() != 0);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_WIDTH-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        capacity = value;
    endtask

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int random_goal;
        capacity = CAP_RESET;
        restart_body();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // extreme payload bytes, then an empty size line ends the body
        push_byte("2", 1'b0);
        push_byte(CHAR_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(CHAR_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte(CHAR_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte("x", 1'b1);
        wait_quiet();

        // long size line, the two bytes after it skipped blind, last on payload
        write_capacity(CAP_TOP);
        repeat (12) push_byte("0", 1'b0);
        push_byte("1", 1'b0);
        push_byte(";", 1'b0);
        push_byte("z", 1'b0);
        push_byte("Q", 1'b0);
        push_byte(CHAR_CR, 1'b0);
        push_byte(8'hA5, 1'b1);
        wait_quiet();

        // capacity of one: nothing may pass
        write_capacity(25'd1);
        push_byte(8'h00, 1'b1);
        wait_quiet();

        // limit reached inside a chunk, then ignored until last
        write_capacity(25'd3);
        push_byte("5", 1'b0);
        push_byte(CHAR_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte("a", 1'b0);
        push_byte("b", 1'b0);
        push_byte("c", 1'b1);
        wait_quiet();

        // capacity lowered below the running total mid body
        write_capacity(CAP_RESET);
        push_byte("9", 1'b0);
        push_byte(CHAR_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte("a", 1'b0);
        push_byte("b", 1'b0);
        wait_quiet();
        write_capacity(25'd2);
        push_byte("c", 1'b1);
        wait_quiet();

        // random bodies in bursts, each burst drained before the next
        random_goal = active_bytes + RANDOM_BYTES;
        while (active_bytes < random_goal) begin
            if ($urandom_range(0, 1) == 0) write_capacity(pick_capacity());
            repeat ($urandom_range(2, 8)) begin
                if ($urandom_range(0, 9) < 7) push_body();
                else push_broken();
            end
            wait_quiet();
        end

        if (decode_errors == 0 && decoded_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
